// ===== src/sr2dc_pkg.sv =====
// Shared constants, types and functions of the signed radix to digit characters unit.
`default_nettype none

package sr2dc_pkg;

    localparam int MAX_DIGITS = 64;
    localparam int MAX_RADIX  = 16;
    localparam int DIG_W      = 4;
    localparam int ADDR_W     = 6;
    localparam int CNT_W      = 7;
    localparam int RADIX_W    = 5;
    localparam int VALUE_W    = 64;
    localparam int SYM_W      = 8;
    localparam int REG_IDX_W  = 2;
    localparam int BYTE_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_RADIX        = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0] RADIX_RESET        = 5'd10;
    localparam logic [63:0]        SYMBOLS_LOW_RESET  = 64'h3736353433323130;
    localparam logic [63:0]        SYMBOLS_HIGH_RESET = 64'h4645444342413938;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic emit_en;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic last_byte;
        logic read_last;
    } stat_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        if (r < RADIX_W'(2))
            res = RADIX_W'(2);
        else if (r > RADIX_W'(MAX_RADIX))
            res = RADIX_W'(MAX_RADIX);
        else
            res = r;
        return res;
    endfunction

    function automatic logic [BYTE_IDX_W-1:0] top_byte(input logic [VALUE_W-1:0] v);
        logic [BYTE_IDX_W-1:0] res;
        res = '0;
        for (int i = 0; i < VALUE_W / 8; i++) begin
            if (v[i*8 +: 8] != 8'd0)
                res = BYTE_IDX_W'(i);
        end
        return res;
    endfunction

    function automatic logic [SYM_W-1:0] symbol_of(input logic [DIG_W-1:0] d,
                                                   input logic [63:0] lo,
                                                   input logic [63:0] hi);
        logic [SYM_W-1:0] res;
        if (d[3])
            res = hi[{d[2:0], 3'b000} +: 8];
        else
            res = lo[{d[2:0], 3'b000} +: 8];
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== src/signed_radix_to_digit_chars_unit.sv =====
// Top level: signed 64-bit value to radix digit symbols, most significant first.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | value[63:0] signed
//  out     | output    | out_valid/out_stall| symbol[7:0], negative, last_symbol
//  config  | input     | wr_en              | wr_index[1:0], wr_data[63:0]
//
// Each digit takes a setup step and then one divide step per byte of the
// magnitude up to its highest nonzero byte (at least one); the byte-wise
// divider gives 8 quotient bits per cycle. Emission then runs one symbol per
// cycle out of the digit RAM while out_stall is low, through the registered
// RAM read and the output register.
// Reset is asynchronous and needs no clearing pass. out_stall holds the output
// word and pauses reads; the digit store feeds it again once the stall drops.
`default_nettype none

module signed_radix_to_digit_chars_unit
    import sr2dc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic signed [63:0]   value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SYM_W-1:0]          symbol,
    output logic                      negative,
    output logic                      last_symbol,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [63:0]          wr_data
);

    cmd_t  cmd;
    stat_t stat;

    sr2dc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    sr2dc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .value       (value),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .symbol      (symbol),
        .negative    (negative),
        .last_symbol (last_symbol)
    );

endmodule

`default_nettype wire

// ===== src/sr2dc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module sr2dc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/sr2dc_ctrl.sv =====
// Controller state machine: load, per digit division sequencing, emission.
`default_nettype none

module sr2dc_ctrl
    import sr2dc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DSTART,
        S_DIVIDE,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.div_init = (state_reg == S_DSTART) && !stat.conv_done;
        cmd.div_step = (state_reg == S_DIVIDE);
        cmd.emit_en  = (state_reg == S_EMIT);
        state_next   = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_DSTART;
            end
            S_DSTART:
            begin
                state_next = stat.conv_done ? S_EMIT : S_DIVIDE;
            end
            S_DIVIDE:
            begin
                if (stat.last_byte)
                    state_next = S_DSTART;
            end
            S_EMIT:
            begin
                if (stat.read_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sr2dc_dp.sv =====
// Datapath: config registers, byte-wise divider, digit store and output stages.
`default_nettype none

module sr2dc_dp
    import sr2dc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cmd_t                 cmd,
    output stat_t                     stat,
    input  wire logic signed [63:0]   value,
    input  wire logic                 wr_en,
    input  wire logic [REG_IDX_W-1:0] wr_index,
    input  wire logic [63:0]          wr_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [SYM_W-1:0]          symbol,
    output logic                      negative,
    output logic                      last_symbol
);

    logic [RADIX_W-1:0]    radix_reg;
    logic [63:0]           symbols_low_reg;
    logic [63:0]           symbols_high_reg;

    logic [VALUE_W-1:0]    mag_reg;
    logic [VALUE_W-1:0]    mag_next;
    logic [DIG_W-1:0]      rem_reg;
    logic [DIG_W-1:0]      rem_next;
    logic [BYTE_IDX_W-1:0] idx_reg;
    logic [BYTE_IDX_W-1:0] idx_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  sign_reg;
    logic                  sign_next;

    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic                  s1_last_reg;
    logic                  s1_neg_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [SYM_W-1:0]      symbol_reg;
    logic                  negative_reg;
    logic                  last_reg;

    logic [RADIX_W-1:0]    radix_eff;
    logic [VALUE_W-1:0]    value_u;
    logic [7:0]            cur_byte;
    logic [7:0]            qbyte;
    logic [DIG_W-1:0]      rem_w;
    logic [RADIX_W-1:0]    trial;
    logic                  digit_we;
    logic                  rd_en;
    logic                  out_load;
    logic [DIG_W-1:0]      rd_digit;

    assign radix_eff = eff_radix(radix_reg);
    assign value_u   = value;

    // restoring division of one dividend byte, remainder stays below the radix
    always_comb
    begin
        rem_w    = rem_reg;
        qbyte    = '0;
        cur_byte = mag_reg[{idx_reg, 3'b000} +: 8];
        for (int i = 7; i >= 0; i--)
        begin
            trial = {rem_w, cur_byte[i]};
            if (trial >= radix_eff)
            begin
                qbyte[i] = 1'b1;
                rem_w    = DIG_W'(trial - radix_eff);
            end
            else
            begin
                rem_w = trial[DIG_W-1:0];
            end
        end
    end

    assign digit_we = cmd.div_step && (idx_reg == '0);
    assign out_load = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign rd_en    = cmd.emit_en && (count_reg != '0) && (!s1_valid_reg || out_load);

    assign stat.conv_done = (count_reg != '0) && ((mag_reg == '0) || count_reg[CNT_W-1]);
    assign stat.last_byte = (idx_reg == '0);
    assign stat.read_last = rd_en && (count_reg == CNT_W'(1));

    always_comb
    begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        sign_next  = sign_reg;
        if (cmd.load)
        begin
            mag_next   = value_u[VALUE_W-1] ? (~value_u + VALUE_W'(1)) : value_u;
            sign_next  = value_u[VALUE_W-1];
            count_next = '0;
        end
        if (cmd.div_init)
        begin
            rem_next = '0;
            idx_next = top_byte(mag_reg);
        end
        if (cmd.div_step)
        begin
            mag_next[{idx_reg, 3'b000} +: 8] = qbyte;
            rem_next = rem_w;
            idx_next = idx_reg - BYTE_IDX_W'(1);
        end
        if (digit_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (rd_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rd_en)
            s1_valid_next = 1'b1;
        else if (out_load)
            s1_valid_next = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            symbols_low_reg  <= SYMBOLS_LOW_RESET;
            symbols_high_reg <= SYMBOLS_HIGH_RESET;
            count_reg        <= '0;
            sign_reg         <= 1'b0;
            mag_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_RADIX:        radix_reg        <= wr_data[RADIX_W-1:0];
                    REG_SYMBOLS_LOW:  symbols_low_reg  <= wr_data;
                    REG_SYMBOLS_HIGH: symbols_high_reg <= wr_data;
                    default:          ;
                endcase
            end
            count_reg     <= count_next;
            sign_reg      <= sign_next;
            mag_reg       <= mag_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        idx_reg <= idx_next;
        if (rd_en)
        begin
            s1_last_reg <= (count_reg == CNT_W'(1));
            s1_neg_reg  <= sign_reg;
        end
        if (out_load)
        begin
            symbol_reg   <= symbol_of(rd_digit, symbols_low_reg, symbols_high_reg);
            negative_reg <= s1_neg_reg;
            last_reg     <= s1_last_reg;
        end
    end

    sr2dc_ram #(
        .WIDTH (DIG_W),
        .DEPTH (MAX_DIGITS)
    ) u_digits (
        .clk   (clk),
        .we    (digit_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (rem_w),
        .re    (rd_en),
        .raddr (ADDR_W'(count_reg - CNT_W'(1))),
        .rdata (rd_digit)
    );

    assign out_valid   = out_valid_reg;
    assign symbol      = symbol_reg;
    assign negative    = negative_reg;
    assign last_symbol = last_reg;

endmodule

`default_nettype wire

// ===== src/sr2dc_chk.sv =====
// Port-level checker for the digit characters unit, bound to the top level.
`default_nettype none

module sr2dc_chk
    import sr2dc_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [SYM_W-1:0] symbol,
    input wire logic             negative,
    input wire logic             last_symbol
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(symbol)
            && $stable(negative) && $stable(last_symbol))
        else $error("stalled output word changed");

    // every conversion goes through a setup state and at least one divide state
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input taken again too early");

    // going idle means the last word is issued and shows up on the output
    a_last_follows_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |=> out_valid)
        else $error("no output word after conversion finished");

endmodule

bind signed_radix_to_digit_chars_unit sr2dc_chk u_sr2dc_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .symbol      (symbol),
    .negative    (negative),
    .last_symbol (last_symbol)
);

`default_nettype wire
